FILE: hdl/brlr_pkg.sv
// Shared types and constants for the blended rectangle/line rasterizer.
// Used by brlr_ctrl, brlr_dp and blended_rect_line_raster.
`timescale 1ns / 1ps

package brlr_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int X_W        = $clog2(MAX_WIDTH);
   localparam int Y_W        = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 9;
   localparam int COORD_W    = 13;
   localparam int COUNT_W    = 17;
   localparam int PIX_W      = 24;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
   localparam logic [SIZE_W-1:0] MAX_W_SIZE = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_H_SIZE = SIZE_W'(MAX_HEIGHT);

   // command codes
   localparam logic [1:0] CMD_FILL = 2'd0;
   localparam logic [1:0] CMD_LINE = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   // config register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic rd_issue;
      logic capture;
      logic mix;
      logic wr;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic       clr_last;
      logic [1:0] op;
      logic       empty;
      logic       last;
   } ctl_stat_type;

endpackage

FILE: hdl/blended_rect_line_raster.sv
// Flow from accept to response: setup, then per pixel read, blend and write for
// fill/line, or read and capture for a pixel read; a command with nothing to
// draw goes from setup straight to the response. One transaction at a time; a
// new request is accepted only in idle, after the response has been loaded.
// Reset: after reset a clearing pass writes zero to all 65536 pixels, one per
// cycle; requests are held off until it ends. Config registers reset to 256.
`timescale 1ns / 1ps

module blended_rect_line_raster import brlr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_first_x,
   input  logic signed [COORD_W-1:0] req_first_y,
   input  logic signed [COORD_W-1:0] req_second_x,
   input  logic signed [COORD_W-1:0] req_second_y,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_alpha,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_read_red,
   output logic [7:0]                rsp_read_green,
   output logic [7:0]                rsp_read_blue,
   output logic [COUNT_W-1:0]        rsp_pixels_drawn,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [SIZE_W-1:0]         csr_data
);

   logic [SIZE_W-1:0] frame_width_ff, frame_height_ff;
   logic [SIZE_W-1:0] frame_w, frame_h;
   ctl_cmd_type       cmd;
   ctl_stat_type      stat;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= MAX_W_SIZE;
         frame_height_ff <= MAX_H_SIZE;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIDTH:  frame_width_ff  <= csr_data;
            CSR_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // registers saturate into 1..max when used
   always_comb begin
      if (frame_width_ff == '0)            frame_w = SIZE_W'(1);
      else if (frame_width_ff > MAX_W_SIZE) frame_w = MAX_W_SIZE;
      else                                 frame_w = frame_width_ff;
      if (frame_height_ff == '0)            frame_h = SIZE_W'(1);
      else if (frame_height_ff > MAX_H_SIZE) frame_h = MAX_H_SIZE;
      else                                  frame_h = frame_height_ff;
   end

   brlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   brlr_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .frame_w          (frame_w),
      .frame_h          (frame_h),
      .req_cmd          (req_cmd),
      .req_first_x      (req_first_x),
      .req_first_y      (req_first_y),
      .req_second_x     (req_second_x),
      .req_second_y     (req_second_y),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_alpha        (req_alpha),
      .rsp_read_red     (rsp_read_red),
      .rsp_read_green   (rsp_read_green),
      .rsp_read_blue    (rsp_read_blue),
      .rsp_pixels_drawn (rsp_pixels_drawn)
   );

endmodule

FILE: hdl/brlr_ctrl.sv
// Controller for the rasterizer: clearing pass, per-pixel read-modify-write
// sequencing and the request/response handshakes. Depends on brlr_pkg.
`timescale 1ns / 1ps

module brlr_ctrl import brlr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR   = 8'b0000_0001,
      ST_IDLE    = 8'b0000_0010,
      ST_SETUP   = 8'b0000_0100,
      ST_READ    = 8'b0000_1000,
      ST_CAPTURE = 8'b0001_0000,
      ST_MIX     = 8'b0010_0000,
      ST_WRITE   = 8'b0100_0000,
      ST_DONE    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (stat.op == CMD_NONE || (stat.op == CMD_FILL && stat.empty))
               state_in = ST_DONE;
            else
               state_in = ST_READ;
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in = (stat.op == CMD_READ) ? ST_CAPTURE : ST_MIX;
         end
         ST_CAPTURE: begin
            cmd.capture = 1'b1;
            state_in = ST_DONE;
         end
         ST_MIX: begin
            cmd.mix  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = stat.last ? ST_DONE : ST_READ;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/brlr_dp.sv
// Datapath for the rasterizer: point clamping, pixel walker, frame store,
// alpha blend and the response registers. Depends on brlr_pkg.
`timescale 1ns / 1ps

module brlr_dp import brlr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               cmd,
   output ctl_stat_type              stat,
   input  logic [SIZE_W-1:0]         frame_w,
   input  logic [SIZE_W-1:0]         frame_h,
   input  logic [1:0]                req_cmd,
   input  logic signed [COORD_W-1:0] req_first_x,
   input  logic signed [COORD_W-1:0] req_first_y,
   input  logic signed [COORD_W-1:0] req_second_x,
   input  logic signed [COORD_W-1:0] req_second_y,
   input  logic [7:0]                req_red,
   input  logic [7:0]                req_green,
   input  logic [7:0]                req_blue,
   input  logic [7:0]                req_alpha,
   output logic [7:0]                rsp_read_red,
   output logic [7:0]                rsp_read_green,
   output logic [7:0]                rsp_read_blue,
   output logic [COUNT_W-1:0]        rsp_pixels_drawn
);

   function automatic logic [X_W-1:0] clamp_coord(logic signed [COORD_W-1:0] v,
                                                   logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] top;
      logic [X_W-1:0]    res;
      top = size - SIZE_W'(1);
      if (v[COORD_W-1])
         res = '0;
      else if ($unsigned(v[COORD_W-2:0]) >= (COORD_W-1)'(size))
         res = top[X_W-1:0];
      else
         res = v[X_W-1:0];
      return res;
   endfunction

   // x/255 for x up to 255*255, the largest blend sum
   function automatic logic [7:0] div255(logic [15:0] n);
      logic [16:0] t;
      t = {1'b0, n} + 17'(n[15:8]) + 17'd1;
      return t[15:8];
   endfunction

   logic [PIX_W-1:0]   mem [0:STORE_SIZE-1];
   logic [PIX_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W:0]    addr_full;
   logic [ADDR_W-1:0]  addr_in;

   logic [1:0]         op_ff;
   logic [X_W-1:0]     x1_ff, x2_ff, walk_x_ff, walk_x_in;
   logic [Y_W-1:0]     y1_ff, y2_ff, walk_y_ff, walk_y_in;
   logic [SIZE_W-1:0]  w_ff;
   logic [7:0]         red_ff, green_ff, blue_ff, alpha_ff;
   logic [15:0]        sum_r_ff, sum_g_ff, sum_b_ff;
   logic [7:0]         inv_a;
   logic [PIX_W-1:0]   blended;
   logic [COUNT_W-1:0] count_ff;
   logic [7:0]         res_r_ff, res_g_ff, res_b_ff;

   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [PIX_W-1:0]   mem_wdata;

   assign stat.clr_last = (clr_addr_ff == LAST_ADDR);
   assign stat.op       = op_ff;
   assign stat.empty    = (x1_ff > x2_ff) || (y1_ff > y2_ff);
   assign stat.last     = (walk_x_ff == x2_ff) && (walk_y_ff == y2_ff);

   // index = x + y*width; always below the store size after clamping
   assign addr_full = (ADDR_W+1)'(walk_y_ff) * (ADDR_W+1)'(w_ff) + (ADDR_W+1)'(walk_x_ff);
   assign addr_in   = addr_full[ADDR_W-1:0];

   assign inv_a   = 8'd255 - alpha_ff;
   assign blended = {div255(sum_r_ff), div255(sum_g_ff), div255(sum_b_ff)};

   // next walker position
   always_comb begin
      walk_x_in = walk_x_ff;
      walk_y_in = walk_y_ff;
      if (op_ff == CMD_FILL) begin
         if (walk_y_ff == y2_ff) begin
            walk_y_in = y1_ff;
            walk_x_in = walk_x_ff + X_W'(1);
         end else begin
            walk_y_in = walk_y_ff + Y_W'(1);
         end
      end else begin
         if (walk_x_ff < x2_ff)      walk_x_in = walk_x_ff + X_W'(1);
         else if (walk_x_ff > x2_ff) walk_x_in = walk_x_ff - X_W'(1);
         if (walk_y_ff < y2_ff)      walk_y_in = walk_y_ff + Y_W'(1);
         else if (walk_y_ff > y2_ff) walk_y_in = walk_y_ff - Y_W'(1);
      end
   end

   assign mem_we    = cmd.clr_step || cmd.wr;
   assign mem_waddr = cmd.clr_step ? clr_addr_ff : addr_ff;
   assign mem_wdata = cmd.clr_step ? '0 : blended;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      if (cmd.rd_issue) rd_data_ff <= mem[addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset)
         clr_addr_ff <= '0;
      else if (cmd.clr_step)
         clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= CMD_NONE;
      end else if (cmd.load) begin
         op_ff <= req_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x1_ff     <= clamp_coord(req_first_x, frame_w);
         y1_ff     <= clamp_coord(req_first_y, frame_h);
         x2_ff     <= clamp_coord(req_second_x, frame_w);
         y2_ff     <= clamp_coord(req_second_y, frame_h);
         walk_x_ff <= clamp_coord(req_first_x, frame_w);
         walk_y_ff <= clamp_coord(req_first_y, frame_h);
         w_ff      <= frame_w;
         red_ff    <= req_red;
         green_ff  <= req_green;
         blue_ff   <= req_blue;
         alpha_ff  <= req_alpha;
         count_ff  <= '0;
         res_r_ff  <= '0;
         res_g_ff  <= '0;
         res_b_ff  <= '0;
      end else begin
         if (cmd.rd_issue) addr_ff <= addr_in;
         if (cmd.mix) begin
            sum_r_ff <= 16'(red_ff) * 16'(alpha_ff) + 16'(rd_data_ff[23:16]) * 16'(inv_a);
            sum_g_ff <= 16'(green_ff) * 16'(alpha_ff) + 16'(rd_data_ff[15:8]) * 16'(inv_a);
            sum_b_ff <= 16'(blue_ff) * 16'(alpha_ff) + 16'(rd_data_ff[7:0]) * 16'(inv_a);
         end
         if (cmd.wr) begin
            count_ff <= count_ff + COUNT_W'(1);
            if (!stat.last) begin
               walk_x_ff <= walk_x_in;
               walk_y_ff <= walk_y_in;
            end
         end
         if (cmd.capture) begin
            res_r_ff <= rd_data_ff[23:16];
            res_g_ff <= rd_data_ff[15:8];
            res_b_ff <= rd_data_ff[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_read_red     <= res_r_ff;
         rsp_read_green   <= res_g_ff;
         rsp_read_blue    <= res_b_ff;
         rsp_pixels_drawn <= count_ff;
      end
   end

endmodule
